>>> rtl/i2cbr_pkg.sv
// ----------------------------------------------------------------------------
// I2C bus recovery package
// Shared types and constants for the I2C bus-clear sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbr_pkg;

  localparam int unsigned DelayWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam logic [CfgWidth-1:0] DelayReset = CfgWidth'(10);
  localparam longint unsigned DelayMax = (64'd1 << DelayWidth) - 64'd1;

  typedef struct packed {
    logic start_recovery;
    logic scl_level;
    logic sda_level;
  } i2cbr_in_t;

  typedef struct packed {
    logic scl_drive_low;
    logic sda_drive_low;
    logic busy_res;
    logic done_res;
  } i2cbr_out_t;

  typedef enum logic [7:0] {
    PhIdle     = 8'b0000_0001,
    PhWait     = 8'b0000_0010,
    PhPre      = 8'b0000_0100,
    PhClkLow   = 8'b0000_1000,
    PhClkHigh  = 8'b0001_0000,
    PhStart    = 8'b0010_0000,
    PhStartScl = 8'b0100_0000,
    PhStop     = 8'b1000_0000
  } i2cbr_phase_e;

endpackage

`default_nettype wire

>>> rtl/i2c_bus_recovery_unit.sv
// ----------------------------------------------------------------------------
// I2C bus recovery unit
// Bus-clear sequencer stepped once per tick beat with sampled SCL and SDA.
// ----------------------------------------------------------------------------
// Each input beat is one timer tick and yields exactly one result beat. The
// phase and interval counter are updated in the cycle the beat is accepted
// and the result is captured in an output register backed by a one-entry
// skid register, so a new beat is taken every clock cycle unless the input
// is stalled; a beat's result appears in the next cycle when output is free.
// The timing interval is programmed through the configuration channel and is
// meant to be written only while no recovery sequence is running.
`default_nettype none

module i2c_bus_recovery_unit
  import i2cbr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgWidth-1:0] cfg_delay_ticks_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire i2cbr_in_t           in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output i2cbr_out_t               out_data_o
);

  logic [CfgWidth-1:0]   delay_q;
  i2cbr_phase_e          phase_q, phase_d;
  logic [DelayWidth-1:0] count_q, count_d;
  logic [DelayWidth-1:0] eff_delay;
  logic [DelayWidth:0]   count_inc;
  logic                  elapsed;
  logic                  done;
  i2cbr_out_t            res;
  i2cbr_out_t            out_q, out_d, skid_q;
  logic                  out_valid_q, out_valid_d;
  logic                  skid_valid_q, skid_valid_d;
  logic                  accept_in, out_free, load_skid;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept_in   = in_valid_i & ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign eff_delay = (delay_q == '0) ? DelayWidth'(1) :
                     (64'(delay_q) > DelayMax) ? DelayWidth'(DelayMax) :
                     DelayWidth'(delay_q);
  assign count_inc = {1'b0, count_q} + (DelayWidth+1)'(1);
  assign elapsed   = count_inc >= {1'b0, eff_delay};

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    done    = 1'b0;
    if (phase_q == PhPre || phase_q == PhClkLow || phase_q == PhClkHigh ||
        phase_q == PhStart || phase_q == PhStartScl || phase_q == PhStop) begin
      count_d = elapsed ? '0 : count_inc[DelayWidth-1:0];
    end
    case (phase_q)
      PhIdle: begin
        if (in_data_i.start_recovery) begin
          phase_d = PhWait;
          count_d = '0;
        end
      end
      PhWait: begin
        if (in_data_i.sda_level) begin
          phase_d = PhStart;
          count_d = '0;
        end else if (in_data_i.scl_level) begin
          phase_d = PhPre;
          count_d = '0;
        end
      end
      PhPre: begin
        if (elapsed) phase_d = PhClkLow;
      end
      PhClkLow: begin
        if (elapsed) phase_d = PhClkHigh;
      end
      PhClkHigh: begin
        if (elapsed) phase_d = PhWait;
      end
      PhStart: begin
        if (elapsed) phase_d = PhStartScl;
      end
      PhStartScl: begin
        if (elapsed) phase_d = PhStop;
      end
      PhStop: begin
        if (elapsed) begin
          phase_d = PhIdle;
          done    = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
        count_d = '0;
      end
    endcase
  end

  always_comb begin
    res = '{scl_drive_low: 1'b0, sda_drive_low: 1'b0, busy_res: 1'b1, done_res: done};
    case (phase_d)
      PhClkLow: res.scl_drive_low = 1'b1;
      PhStart, PhStop: res.sda_drive_low = 1'b1;
      PhStartScl: begin
        res.scl_drive_low = 1'b1;
        res.sda_drive_low = 1'b1;
      end
      PhIdle: res.busy_res = 1'b0;
      default: res.busy_res = 1'b1;
    endcase
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_skid    = 1'b0;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (accept_in) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept_in) begin
      load_skid    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q      <= DelayReset;
      phase_q      <= PhIdle;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) delay_q <= cfg_delay_ticks_i;
      if (accept_in) begin
        phase_q <= phase_d;
        count_q <= count_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load_skid) skid_q <= res;
  end

endmodule

`default_nettype wire

>>> rtl/i2cbr_checker.sv
// ----------------------------------------------------------------------------
// I2C bus recovery checker
// Port-level assertions for the bus recovery unit, bound into the recovery unit module.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbr_checker
  import i2cbr_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire i2cbr_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result beat changed or dropped.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |->
      !out_data_o.busy_res && !out_data_o.scl_drive_low && !out_data_o.sda_drive_low)
    else $error("Done beat shows busy or driven lines.");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("Accepted beat produced no result.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled with no pending result.");

  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_stall_i) && $past(in_valid_i))
    else $error("Input stall rose without a stalled output.");

endmodule

bind i2c_bus_recovery_unit i2cbr_checker u_i2cbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the I2C bus recovery unit
// Drives tick beats with sampled SCL and SDA levels through the stall
// handshake, predicts result beats with a local model of the bus-clear sequencer
// or a typed directed row, and checks line drives, busy and done field by field.
// A short directed table comes first, then random traffic over several delay settings.
// ----------------------------------------------------------------------------

module tb_top;
  import i2cbr_pkg::*;

  localparam i2cbr_out_t OutIdle   = 4'b0000;
  localparam i2cbr_out_t OutBusy   = 4'b0010;
  localparam i2cbr_out_t OutClkLow = 4'b1010;
  localparam i2cbr_out_t OutSdaLow = 4'b0110;
  localparam i2cbr_out_t OutBoth   = 4'b1110;
  localparam i2cbr_out_t OutDone   = 4'b0001;
  localparam int DirCount = 25;

  typedef struct packed {
    logic                set_delay;
    logic [CfgWidth-1:0] delay;
    i2cbr_in_t           tick;
    logic                typed;
    i2cbr_out_t          result;
  } dir_row_t;

  localparam dir_row_t DirRows [DirCount] = '{
    '{1'b0, 16'd0, 3'b011, 1'b1, OutIdle},
    '{1'b0, 16'd0, 3'b000, 1'b1, OutIdle},
    '{1'b1, 16'd1, 3'b100, 1'b1, OutBusy},
    '{1'b0, 16'd0, 3'b100, 1'b1, OutBusy},
    '{1'b0, 16'd0, 3'b010, 1'b1, OutBusy},
    '{1'b0, 16'd0, 3'b000, 1'b1, OutClkLow},
    '{1'b0, 16'd0, 3'b000, 1'b1, OutBusy},
    '{1'b0, 16'd0, 3'b000, 1'b1, OutBusy},
    '{1'b0, 16'd0, 3'b001, 1'b1, OutSdaLow},
    '{1'b0, 16'd0, 3'b000, 1'b1, OutBoth},
    '{1'b0, 16'd0, 3'b000, 1'b1, OutSdaLow},
    '{1'b0, 16'd0, 3'b111, 1'b1, OutDone},
    '{1'b0, 16'd0, 3'b011, 1'b1, OutIdle},
    '{1'b1, 16'd0, 3'b111, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b011, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b000, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b000, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b000, 1'b0, OutIdle},
    '{1'b1, 16'd3, 3'b100, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b000, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b010, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b110, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b000, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b101, 1'b0, OutIdle},
    '{1'b0, 16'd0, 3'b010, 1'b0, OutIdle}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgWidth-1:0] cfg_delay_ticks_i;
  logic                in_valid_i;
  logic                in_stall_o;
  i2cbr_in_t           in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  i2cbr_out_t          out_data_o;

  i2cbr_phase_e        pred_phase;
  logic [DelayWidth-1:0] pred_count;
  logic [CfgWidth-1:0] pred_delay;
  i2cbr_out_t          expected_drive_q [$];

  int  errors;
  int  ticks_sent;
  int  results_seen;
  int  dones_seen;
  int  pulses_made;
  int  settings_used;
  bit  idle_en;

  i2c_bus_recovery_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_delay_ticks_i (cfg_delay_ticks_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_data_i         (in_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_data_o        (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic interval_elapsed();
    logic [DelayWidth:0]   nxt;
    logic [DelayWidth-1:0] lim;
    lim = (pred_delay == '0) ? DelayWidth'(1) :
          (64'(pred_delay) > DelayMax) ? DelayWidth'(DelayMax) :
          DelayWidth'(pred_delay);
    nxt = {1'b0, pred_count} + 1'b1;
    if (nxt >= {1'b0, lim}) begin
      pred_count = '0;
      return 1'b1;
    end
    pred_count = nxt[DelayWidth-1:0];
    return 1'b0;
  endfunction

  function automatic i2cbr_out_t bus_clear_step(input i2cbr_in_t tick);
    i2cbr_out_t res;
    res = '0;
    res.busy_res = 1'b1;
    case (pred_phase)
      PhIdle: begin
        if (tick.start_recovery) begin
          pred_phase = PhWait;
          pred_count = '0;
        end
      end
      PhWait: begin
        if (tick.sda_level) begin
          pred_phase = PhStart;
          pred_count = '0;
        end else if (tick.scl_level) begin
          pred_phase = PhPre;
          pred_count = '0;
        end
      end
      PhPre: begin
        if (interval_elapsed()) begin
          pred_phase = PhClkLow;
          pulses_made++;
        end
      end
      PhClkLow:   if (interval_elapsed()) pred_phase = PhClkHigh;
      PhClkHigh:  if (interval_elapsed()) pred_phase = PhWait;
      PhStart:    if (interval_elapsed()) pred_phase = PhStartScl;
      PhStartScl: if (interval_elapsed()) pred_phase = PhStop;
      PhStop: begin
        if (interval_elapsed()) begin
          pred_phase = PhIdle;
          res.done_res = 1'b1;
        end
      end
      default: begin
        pred_phase = PhIdle;
        pred_count = '0;
      end
    endcase
    case (pred_phase)
      PhClkLow: res.scl_drive_low = 1'b1;
      PhStart, PhStop: res.sda_drive_low = 1'b1;
      PhStartScl: begin
        res.scl_drive_low = 1'b1;
        res.sda_drive_low = 1'b1;
      end
      PhIdle: res.busy_res = 1'b0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic i2cbr_in_t random_tick();
    i2cbr_in_t t;
    if ($urandom_range(0, 4) == 0) begin
      t = i2cbr_in_t'(3'($urandom_range(0, 7)));
    end else begin
      t.start_recovery = ($urandom_range(0, 3) == 0);
      t.scl_level      = ($urandom_range(0, 3) != 0);
      t.sda_level      = ($urandom_range(0, 5) == 0);
    end
    return t;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic got, input logic want);
    if (got !== want) report_mismatch($sformatf("%s got %b want %b", field, got, want));
  endtask

  task automatic send_tick(input i2cbr_in_t tick, input logic use_typed,
                           input i2cbr_out_t typed);
    int gap;
    i2cbr_out_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = bus_clear_step(tick);
    expected_drive_q.push_back(use_typed ? typed : predicted);
    ticks_sent++;
  endtask

  task automatic wait_results(input int settle);
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic finish_sequence();
    i2cbr_in_t t;
    while (pred_phase != PhIdle) begin
      t = random_tick();
      t.sda_level = 1'b1;
      send_tick(t, 1'b0, OutIdle);
    end
    wait_results(4);
  endtask

  task automatic write_delay(input logic [CfgWidth-1:0] value);
    cfg_valid_i       <= 1'b1;
    cfg_delay_ticks_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pred_delay = value;
    settings_used++;
  endtask

  always @(posedge clk_i) begin
    i2cbr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_drive_q.size() == 0) begin
        report_mismatch("result beat with no expected result waiting");
      end else begin
        want = expected_drive_q.pop_front();
        if (want.done_res) dones_seen++;
        check_field("scl_drive_low", out_data_o.scl_drive_low, want.scl_drive_low);
        check_field("sda_drive_low", out_data_o.sda_drive_low, want.sda_drive_low);
        check_field("busy_res", out_data_o.busy_res, want.busy_res);
        check_field("done_res", out_data_o.done_res, want.done_res);
      end
    end
  end

  initial begin
    int n;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  initial begin
    #50_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int counted;
    i2cbr_in_t t;
    logic [CfgWidth-1:0] delays [4];
    rst_ni            <= 1'b0;
    cfg_valid_i       <= 1'b0;
    cfg_delay_ticks_i <= '0;
    in_valid_i        <= 1'b0;
    in_data_i         <= '0;
    out_stall_i       <= 1'b0;
    pred_phase    = PhIdle;
    pred_count    = '0;
    pred_delay    = DelayReset;
    errors        = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    dones_seen    = 0;
    pulses_made   = 0;
    settings_used = 0;
    idle_en       = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      if (DirRows[i].set_delay) begin
        finish_sequence();
        write_delay(DirRows[i].delay);
      end
      send_tick(DirRows[i].tick, DirRows[i].typed, DirRows[i].result);
    end
    finish_sequence();

    idle_en = 1'b0;
    write_delay(CfgWidth'(24));
    t = random_tick();
    t.start_recovery = 1'b1;
    send_tick(t, 1'b0, OutIdle);
    finish_sequence();
    idle_en = 1'b1;

    delays[0] = CfgWidth'(2);
    delays[1] = CfgWidth'($urandom_range(3, 12));
    delays[2] = CfgWidth'(1);
    delays[3] = CfgWidth'($urandom_range(1, 6));
    for (int k = 0; k < 4; k++) begin
      idle_en = (k != 2);
      write_delay(delays[k]);
      counted = 0;
      while (counted < 65) begin
        t = random_tick();
        if (pred_phase != PhIdle || t.start_recovery) counted++;
        send_tick(t, 1'b0, OutIdle);
        if (counted % 60 == 59) wait_results(2);
      end
      finish_sequence();
    end
    idle_en = 1'b1;

    wait_results(8);
    $display("Run covered %0d tick beats and %0d result beats over %0d delay settings.",
             ticks_sent, results_seen, settings_used);
    $display("Sequences completed: %0d, clock pulses driven: %0d.", dones_seen, pulses_made);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
